// ===== design/ptrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared types, widths and constants of the PCM track resample mixer.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  // default track memory depth in 16-bit words
  localparam int unsigned TrackDepthDef = 65536;

  // source track rate, added to the rate phase once per output frame
  localparam logic [17:0] TrackRate = 18'd44100;
  // volume/128: product is shifted down by this many bits
  localparam int unsigned GainShift = 7;
  localparam logic [16:0] PosMax = 17'h1FFFF;

  localparam int unsigned MixW    = 32;
  localparam int unsigned SampW   = 16;
  localparam int unsigned LdAddrW = 16;
  localparam int unsigned PosW    = 17;
  localparam int unsigned PhaseW  = 17;
  localparam int unsigned QuotW   = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 17;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_MIX     = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVolume      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOutputRate  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStereoMode  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPlayEnable  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRepeat      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLoopFrame   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTrackWords  = 3'd6;

  // sample * volume, divided by 128 with truncation toward zero, sign-extended
  function automatic logic [MixW-1:0] scale_prod(input logic signed [24:0] prod);
    logic signed [24:0] adj;
    logic signed [24:0] quo;
    adj = prod + (prod[24] ? 25'sd127 : 25'sd0);
    quo = adj >>> GainShift;
    return {{(MixW-25){quo[24]}}, quo};
  endfunction

endpackage

// ===== design/ptrm_if.sv =====
// ----------------------------------------------------------------------------
// ptrm interfaces
// Valid/ready channels for track items, mix results and register writes.
// ----------------------------------------------------------------------------
interface ptrm_item_if import ptrm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  kind_e                      kind;
  logic [LdAddrW-1:0]         load_address;
  logic signed [SampW-1:0]    load_sample;
  logic signed [MixW-1:0]     left_in;
  logic signed [MixW-1:0]     right_in;

  modport source (output valid, kind, load_address, load_sample, left_in, right_in,
                  input ready);
  modport sink   (input valid, kind, load_address, load_sample, left_in, right_in,
                  output ready);
endinterface

interface ptrm_result_if import ptrm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [MixW-1:0]     left_out;
  logic signed [MixW-1:0]     right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface ptrm_cfg_if import ptrm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CfgIdxW-1:0]         index;
  logic [CfgDatW-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pcm_track_resample_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// pcm_track_resample_mixer_unit
// Nearest-neighbor resampling mixer over a stored interleaved 16-bit track.
// ----------------------------------------------------------------------------
// Load, restart and ignored items leave the sequencer idle; the next item is taken at once.
// Stopped or past-end mix: straight to the done step, then back to idle for the next item.
// Playing mix: two track reads, two multiply/add steps, an 18-bit restoring divider,
// position update and done step, in that order; the next item is taken after done.
// A result still waiting in the output register holds the done step.
// Reset restores register defaults and clears position and phase; memory is kept.
module pcm_track_resample_mixer_unit import ptrm_pkg::*; #(
  parameter int unsigned TRACK_DEPTH = TrackDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptrm_item_if.sink    item_i,
  ptrm_cfg_if.sink     cfg_i,
  ptrm_result_if.source result_o
);

  localparam int unsigned AddrW  = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam logic [31:0] DepthW = 32'(TRACK_DEPTH);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDL  = 3'd1;  // left word arrives, right read issued
  localparam logic [2:0] S_RDR  = 3'd2;  // right word arrives, left product
  localparam logic [2:0] S_MULR = 3'd3;  // right product, left add
  localparam logic [2:0] S_ADDR = 3'd4;  // right add in stereo mode, divider load
  localparam logic [2:0] S_DIV  = 3'd5;  // (phase + track rate) / output rate, one bit a cycle
  localparam logic [2:0] S_POS  = 3'd6;  // position update and loop check
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to the output register

  // configuration registers
  logic [7:0]        volume_q;
  logic [16:0]       out_rate_q;
  logic              stereo_q;
  logic              play_q;
  logic              repeat_q;
  logic [14:0]       loop_frame_q;
  logic [16:0]       track_words_q;

  // playback state
  logic [PosW-1:0]   pos_q;
  logic [PhaseW-1:0] phase_q;

  logic [2:0]        state_q;
  logic [4:0]        cnt_q;
  logic [MixW-1:0]   work_l_q, work_r_q;
  logic signed [SampW-1:0] samp_q;
  logic signed [24:0]      prod_l_q, prod_r_q;
  logic [QuotW-1:0]  div_q;
  logic [QuotW-1:0]  rem_q;

  logic              res_valid_q;
  logic [MixW-1:0]   res_l_q, res_r_q;

  // track memory, one port, registered read
  logic [SampW-1:0]  mem [TRACK_DEPTH];
  logic [SampW-1:0]  mem_rdata_q;
  logic              rd_ok_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [31:0]       rd_addr_w;
  logic [31:0]       ld_addr_w;
  logic [SampW-1:0]  rd_word;

  logic              item_xfer, cfg_xfer;
  logic              playing, pos_in_track;
  logic [16:0]       rate_eff;
  logic [QuotW-1:0]  div_trial;
  logic              div_ge;
  logic [19:0]       pos_sum;
  logic [PosW-1:0]   pos_adv;
  logic [PosW-1:0]   pos_loop;
  logic              out_free;

  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign item_xfer    = item_i.valid && item_i.ready;
  assign cfg_xfer     = cfg_i.valid;

  assign playing      = play_q && (track_words_q != 17'd0);
  assign pos_in_track = pos_q < track_words_q;
  assign rate_eff     = (out_rate_q == 17'd0) ? 17'd1 : out_rate_q;
  assign pos_loop     = {1'b0, loop_frame_q, 1'b0};
  assign out_free     = !res_valid_q || result_o.ready;

  // memory port control; a load only happens in idle, reads only on mix flow
  assign ld_addr_w = 32'(item_i.load_address);
  assign mem_we    = item_xfer && (item_i.kind == KIND_LOAD) && (ld_addr_w < DepthW);
  assign mem_waddr = ld_addr_w[AddrW-1:0];
  assign mem_re    = (item_xfer && (item_i.kind == KIND_MIX)) || (state_q == S_RDL);
  assign rd_addr_w = (state_q == S_RDL) ? 32'(pos_q) + 32'd1 : 32'(pos_q);
  assign mem_raddr = rd_addr_w[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= item_i.load_sample;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
      rd_ok_q     <= rd_addr_w < DepthW;
    end
  end

  // reads past the memory depth give silence
  assign rd_word = rd_ok_q ? mem_rdata_q : '0;

  // restoring divider step
  assign div_trial = {rem_q[QuotW-2:0], div_q[QuotW-1]};
  assign div_ge    = div_trial >= {1'b0, rate_eff};

  // saturating advance by two words per whole step
  assign pos_sum = {3'b0, pos_q} + {1'b0, div_q, 1'b0};
  assign pos_adv = (pos_sum > {3'b0, PosMax}) ? PosMax : pos_sum[PosW-1:0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q      <= 8'd255;
      out_rate_q    <= 17'd32000;
      stereo_q      <= 1'b1;
      play_q        <= 1'b0;
      repeat_q      <= 1'b0;
      loop_frame_q  <= '0;
      track_words_q <= '0;
    end else if (cfg_xfer) begin
      case (cfg_i.index)
        RegVolume:     volume_q      <= cfg_i.data[7:0];
        RegOutputRate: out_rate_q    <= cfg_i.data;
        RegStereoMode: stereo_q      <= cfg_i.data[0];
        RegPlayEnable: play_q        <= cfg_i.data[0];
        RegRepeat:     repeat_q      <= cfg_i.data[0];
        RegLoopFrame:  loop_frame_q  <= cfg_i.data[14:0];
        RegTrackWords: track_words_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sequencer and playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q   <= '0;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (item_xfer) begin
            case (item_i.kind)
              KIND_RESTART: begin
                pos_q   <= '0;
                phase_q <= '0;
              end
              KIND_MIX: begin
                if (!playing) begin
                  state_q <= S_DONE;
                end else if (pos_in_track) begin
                  state_q <= S_RDL;
                end else begin
                  // past the end: no sample, only the loop check
                  if (repeat_q) begin
                    pos_q <= pos_loop;
                  end
                  state_q <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDL:  state_q <= S_RDR;
        S_RDR:  state_q <= S_MULR;
        S_MULR: state_q <= S_ADDR;
        S_ADDR: begin
          cnt_q   <= 5'(QuotW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 5'd0) begin
            state_q <= S_POS;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_POS: begin
          phase_q <= rem_q[PhaseW-1:0];
          if ((pos_adv >= track_words_q) && repeat_q) begin
            pos_q <= pos_loop;
          end else begin
            pos_q <= pos_adv;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath: mix values, products, divider
  always_ff @(posedge clk_i) begin
    if (item_xfer && (item_i.kind == KIND_MIX)) begin
      work_l_q <= item_i.left_in;
      work_r_q <= item_i.right_in;
    end
    case (state_q)
      S_RDL:  samp_q <= rd_word;
      S_RDR: begin
        prod_l_q <= 25'(samp_q) * 25'($signed({1'b0, volume_q}));
        samp_q   <= rd_word;
      end
      S_MULR: begin
        prod_r_q <= 25'(samp_q) * 25'($signed({1'b0, volume_q}));
        work_l_q <= work_l_q + scale_prod(prod_l_q);
      end
      S_ADDR: begin
        if (stereo_q) begin
          work_r_q <= work_r_q + scale_prod(prod_r_q);
        end
        div_q <= {1'b0, phase_q} + TrackRate;
        rem_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? div_trial - {1'b0, rate_eff} : div_trial;
        div_q <= {div_q[QuotW-2:0], div_ge};
      end
      default: ;
    endcase
  end

  // output register: a finished result waits here while new items come in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      res_l_q <= work_l_q;
      res_r_q <= work_r_q;
    end
  end

  assign result_o.valid     = res_valid_q;
  assign result_o.left_out  = res_l_q;
  assign result_o.right_out = res_r_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("track memory read and write in the same cycle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !$past(res_valid_q)) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the done step");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POS) |-> (rem_q < {1'b0, rate_eff}))
    else $error("divider remainder not below rate");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |=> ((state_q == S_DIV) && (cnt_q == 5'(QuotW - 1))))
    else $error("divider did not start with a full count");

endmodule
